/* hdl/ppp_pkg.sv */
// Shared types and constants of the perspective point projection block.
`timescale 1ns / 1ps

package ppp_pkg;

  // Field widths
  localparam int PT_W    = 32;             // Q16.16 point coordinate
  localparam int COEF_W  = 16;             // Q4.12 coefficient
  localparam int ROW_W   = 3 * COEF_W;     // packed coefficient row
  localparam int PROD_W  = PT_W + COEF_W;  // one coefficient product
  localparam int OFFS_W  = PT_W + 12;      // offset moved to Q.28
  localparam int CW      = PROD_W + 3;     // clip value, signed Q.28
  localparam int MW      = CW;             // clip magnitude, unsigned
  localparam int GW      = MW + 4;         // 5*|c| and 11*w
  localparam int RW      = MW + 2;         // divider trial difference
  localparam int FRAC    = 30;             // fraction bits of ndc
  localparam int QW      = FRAC + 2;       // ndc magnitude, Q2.30
  localparam int HW_W    = 16;             // half width, Q12.4
  localparam int SXP_W   = QW + HW_W;      // ndc_x * half width
  localparam int YS_W    = 9;              // width of the fixed y scale
  localparam int SYP_W   = QW + YS_W;      // ndc_y * y scale
  localparam int DEPTH_W = 31;
  localparam int SCR_W   = 32;

  localparam logic [YS_W-1:0] Y_SCALE = YS_W'(360);
  // 10*w <= 2^28 is the same as w <= floor(2^28 / 10)
  localparam logic signed [CW-1:0] W_MIN = CW'(26843545);

  // Pipeline stage map
  localparam int ST_DIV  = 6;                // first divider stage
  localparam int ST_MUL  = ST_DIV + FRAC + 1; // screen scale multiply
  localparam int NSTG    = ST_MUL + 2;       // last stage is the output register

  // Configuration port
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;
  localparam logic [2:0] REG_ROW_X  = 3'd0;
  localparam logic [2:0] REG_ROW_Y  = 3'd1;
  localparam logic [2:0] REG_ROW_W  = 3'd2;
  localparam logic [2:0] REG_OFF_X  = 3'd3;
  localparam logic [2:0] REG_OFF_Y  = 3'd4;
  localparam logic [2:0] REG_OFF_W  = 3'd5;
  localparam logic [2:0] REG_HALF_W = 3'd6;

  localparam logic [PT_W-1:0] OFF_W_RST  = 32'd65536;
  localparam logic [HW_W-1:0] HALF_W_RST = 16'd10240;

  // Magnitude data between the clip sums and the divider
  typedef struct packed {
    logic          wlow;
    logic          negx;
    logic          negy;
    logic [MW-1:0] ax;
    logic [MW-1:0] ay;
    logic [MW-1:0] w;
  } mag_t;

  // One divider stage
  typedef struct packed {
    logic          vis;
    logic          negx;
    logic          negy;
    logic [MW-1:0] w;
    logic [MW-1:0] rx;
    logic [MW-1:0] ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } div_t;

endpackage

/* hdl/ppp_in_if.sv */
// Input point channel.
`timescale 1ns / 1ps

interface ppp_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [ppp_pkg::PT_W-1:0] point_x;
  logic signed [ppp_pkg::PT_W-1:0] point_y;
  logic signed [ppp_pkg::PT_W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

/* hdl/ppp_out_if.sv */
// Result channel.
`timescale 1ns / 1ps

interface ppp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             visible;
  logic signed [ppp_pkg::SCR_W-1:0] screen_x;
  logic signed [ppp_pkg::SCR_W-1:0] screen_y;
  logic [ppp_pkg::DEPTH_W-1:0]      depth;

  modport source (output valid, visible, screen_x, screen_y, depth, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, depth, output ready);
endinterface

/* hdl/perspective_point_project.sv */
// Top level: perspective projection pipeline with its register file.
`timescale 1ns / 1ps

// Usage
//   in_ch  : one Q16.16 point (x, y, z) per transfer, valid/ready.
//   out_ch : one result per point (visible, screen_x, screen_y, depth), same order.
//   cfg_*  : APB-style register port, 64-bit data, register i at byte 8*i.
//            Write only while the pipeline is empty.
// Timing
//   One point is taken per cycle while the output is not stalled: three
//   multiply/sum stages, three compare stages, one integer quotient stage,
//   a 30-stage restoring divider (one quotient bit per stage, x and y side
//   by side), one scale multiply and the output stage.
// Reset
//   rst_n clears all valid bits and loads the register reset values.
// Stall
//   When out_ch is not taken the whole pipeline holds; the first stage still
//   takes a point while it is empty. Nothing is dropped or repeated.
module perspective_point_project (
  input  logic                        clk,
  input  logic                        rst_n,
  ppp_in_if.sink                      in_ch,
  ppp_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ppp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [ppp_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [ppp_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CW   = ppp_pkg::CW;
  localparam int MW   = ppp_pkg::MW;
  localparam int GW   = ppp_pkg::GW;
  localparam int RW   = ppp_pkg::RW;
  localparam int QW   = ppp_pkg::QW;
  localparam int FRAC = ppp_pkg::FRAC;
  localparam int NSTG = ppp_pkg::NSTG;

  // ---------------- register file ----------------
  logic [ppp_pkg::ROW_W-1:0]  row_r [0:2];
  logic [ppp_pkg::PT_W-1:0]   off_r [0:2];
  logic [ppp_pkg::HW_W-1:0]   half_w_r;
  logic                       cfg_wr;
  logic [2:0]                 cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[ppp_pkg::CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= '0;
      row_r[2] <= '0;
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= ppp_pkg::OFF_W_RST;
      half_w_r <= ppp_pkg::HALF_W_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ppp_pkg::REG_ROW_X:  row_r[0] <= cfg_pwdata[ppp_pkg::ROW_W-1:0];
        ppp_pkg::REG_ROW_Y:  row_r[1] <= cfg_pwdata[ppp_pkg::ROW_W-1:0];
        ppp_pkg::REG_ROW_W:  row_r[2] <= cfg_pwdata[ppp_pkg::ROW_W-1:0];
        ppp_pkg::REG_OFF_X:  off_r[0] <= cfg_pwdata[ppp_pkg::PT_W-1:0];
        ppp_pkg::REG_OFF_Y:  off_r[1] <= cfg_pwdata[ppp_pkg::PT_W-1:0];
        ppp_pkg::REG_OFF_W:  off_r[2] <= cfg_pwdata[ppp_pkg::PT_W-1:0];
        ppp_pkg::REG_HALF_W: half_w_r <= cfg_pwdata[ppp_pkg::HW_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_idx)
      ppp_pkg::REG_ROW_X:  cfg_prdata = ppp_pkg::CFG_DW'(row_r[0]);
      ppp_pkg::REG_ROW_Y:  cfg_prdata = ppp_pkg::CFG_DW'(row_r[1]);
      ppp_pkg::REG_ROW_W:  cfg_prdata = ppp_pkg::CFG_DW'(row_r[2]);
      ppp_pkg::REG_OFF_X:  cfg_prdata = ppp_pkg::CFG_DW'(off_r[0]);
      ppp_pkg::REG_OFF_Y:  cfg_prdata = ppp_pkg::CFG_DW'(off_r[1]);
      ppp_pkg::REG_OFF_W:  cfg_prdata = ppp_pkg::CFG_DW'(off_r[2]);
      ppp_pkg::REG_HALF_W: cfg_prdata = ppp_pkg::CFG_DW'(half_w_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [NSTG-1:0] v_r;
  logic            en;
  logic            en0;

  assign en          = !v_r[NSTG-1] || out_ch.ready;
  assign en0         = en || !v_r[0];
  assign in_ch.ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en) v_r[NSTG-1:1] <= v_r[NSTG-2:0];
      if (en0) v_r[0] <= in_ch.valid;
    end
  end

  // ---------------- stage 1: coefficient products ----------------
  logic signed [ppp_pkg::PROD_W-1:0] prod_r [0:2][0:2];
  logic signed [ppp_pkg::OFFS_W-1:0] offs_r [0:2];

  always_ff @(posedge clk) begin
    if (en0) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= ppp_pkg::PROD_W'(in_ch.point_x) *
                        ppp_pkg::PROD_W'($signed(row_r[r][15:0]));
        prod_r[r][1] <= ppp_pkg::PROD_W'(in_ch.point_y) *
                        ppp_pkg::PROD_W'($signed(row_r[r][31:16]));
        prod_r[r][2] <= ppp_pkg::PROD_W'(in_ch.point_z) *
                        ppp_pkg::PROD_W'($signed(row_r[r][47:32]));
        offs_r[r]    <= $signed({off_r[r], 12'b0});
      end
    end
  end

  // ---------------- stage 2/3: row sums ----------------
  logic signed [CW-1:0] sa_r [0:2];
  logic signed [CW-1:0] sb_r [0:2];
  logic signed [CW-1:0] clip_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sa_r[r]   <= CW'(prod_r[r][0]) + CW'(prod_r[r][1]);
        sb_r[r]   <= CW'(prod_r[r][2]) + CW'(offs_r[r]);
        clip_r[r] <= sa_r[r] + sb_r[r];
      end
    end
  end

  // ---------------- stage 4: near test and magnitudes ----------------
  ppp_pkg::mag_t mag_r [0:2];
  logic [GW-1:0] ax5_r, ay5_r, w11_r;
  logic          rej_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0].wlow <= clip_r[2] <= ppp_pkg::W_MIN;
      mag_r[0].negx <= clip_r[0][CW-1];
      mag_r[0].negy <= clip_r[1][CW-1];
      mag_r[0].ax   <= clip_r[0][CW-1] ? MW'(-clip_r[0]) : MW'(clip_r[0]);
      mag_r[0].ay   <= clip_r[1][CW-1] ? MW'(-clip_r[1]) : MW'(clip_r[1]);
      mag_r[0].w    <= MW'(clip_r[2]);
      // stage 5: 5*|c| and 11*w
      mag_r[1]      <= mag_r[0];
      ax5_r <= (GW'(mag_r[0].ax) << 2) + GW'(mag_r[0].ax);
      ay5_r <= (GW'(mag_r[0].ay) << 2) + GW'(mag_r[0].ay);
      w11_r <= (GW'(mag_r[0].w) << 3) + (GW'(mag_r[0].w) << 1) + GW'(mag_r[0].w);
      // stage 6: guard band
      mag_r[2]      <= mag_r[1];
      rej_r         <= (ax5_r > w11_r) || (ay5_r > w11_r);
    end
  end

  // ---------------- stage 7: integer quotient bits ----------------
  ppp_pkg::div_t div_r [0:FRAC];
  logic [RW-1:0] dx1, dx2, dy1, dy2;

  assign dx1 = RW'(mag_r[2].ax) - RW'(mag_r[2].w);
  assign dx2 = RW'(mag_r[2].ax) - (RW'(mag_r[2].w) << 1);
  assign dy1 = RW'(mag_r[2].ay) - RW'(mag_r[2].w);
  assign dy2 = RW'(mag_r[2].ay) - (RW'(mag_r[2].w) << 1);

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0].vis  <= !mag_r[2].wlow && !rej_r;
      div_r[0].negx <= mag_r[2].negx;
      div_r[0].negy <= mag_r[2].negy;
      div_r[0].w    <= mag_r[2].w;
      if (!dx2[RW-1]) begin
        div_r[0].rx <= dx2[MW-1:0];
        div_r[0].qx <= QW'(2);
      end else if (!dx1[RW-1]) begin
        div_r[0].rx <= dx1[MW-1:0];
        div_r[0].qx <= QW'(1);
      end else begin
        div_r[0].rx <= mag_r[2].ax;
        div_r[0].qx <= '0;
      end
      if (!dy2[RW-1]) begin
        div_r[0].ry <= dy2[MW-1:0];
        div_r[0].qy <= QW'(2);
      end else if (!dy1[RW-1]) begin
        div_r[0].ry <= dy1[MW-1:0];
        div_r[0].qy <= QW'(1);
      end else begin
        div_r[0].ry <= mag_r[2].ay;
        div_r[0].qy <= '0;
      end
    end
  end

  // one restoring step for both quotients
  function automatic ppp_pkg::div_t div_step(input ppp_pkg::div_t d);
    ppp_pkg::div_t o;
    logic [RW-1:0] tx, ty;
    o  = d;
    tx = {1'b0, d.rx, 1'b0} - RW'(d.w);
    ty = {1'b0, d.ry, 1'b0} - RW'(d.w);
    o.rx = tx[RW-1] ? {d.rx[MW-2:0], 1'b0} : tx[MW-1:0];
    o.ry = ty[RW-1] ? {d.ry[MW-2:0], 1'b0} : ty[MW-1:0];
    o.qx = {d.qx[QW-2:0], !tx[RW-1]};
    o.qy = {d.qy[QW-2:0], !ty[RW-1]};
    return o;
  endfunction

  // ---------------- stages 8..37: fraction bits ----------------
  for (genvar k = 1; k <= FRAC; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) div_r[k] <= div_step(div_r[k-1]);
    end
  end

  // ---------------- stage 38: screen scale ----------------
  logic [ppp_pkg::SXP_W-1:0] sxp_r;
  logic [ppp_pkg::SYP_W-1:0] syp_r;
  logic                      vis_m_r, negx_m_r, negy_m_r;
  logic [MW-1:0]             w_m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sxp_r    <= ppp_pkg::SXP_W'(div_r[FRAC].qx) * ppp_pkg::SXP_W'(half_w_r);
      syp_r    <= ppp_pkg::SYP_W'(div_r[FRAC].qy) * ppp_pkg::SYP_W'(ppp_pkg::Y_SCALE);
      vis_m_r  <= div_r[FRAC].vis;
      negx_m_r <= div_r[FRAC].negx;
      negy_m_r <= div_r[FRAC].negy;
      w_m_r    <= div_r[FRAC].w;
    end
  end

  // ---------------- stage 39: sign, saturation, output register ----------------
  function automatic logic [ppp_pkg::SCR_W-1:0] sat32(input logic [ppp_pkg::SXP_W-1:0] mag,
                                                      input logic neg);
    logic [ppp_pkg::SXP_W-1:0] m;
    m = mag;
    if (neg) begin
      if (m > ppp_pkg::SXP_W'(33'h0_8000_0000)) m = ppp_pkg::SXP_W'(33'h0_8000_0000);
      return ppp_pkg::SCR_W'(~m + ppp_pkg::SXP_W'(1));
    end
    if (m > ppp_pkg::SXP_W'(32'h7FFF_FFFF)) m = ppp_pkg::SXP_W'(32'h7FFF_FFFF);
    return m[ppp_pkg::SCR_W-1:0];
  endfunction

  logic [ppp_pkg::SXP_W-1:0]   sx_mag, sy_mag;
  logic [MW-13:0]              d_full;
  logic [ppp_pkg::DEPTH_W-1:0] d_sat;

  assign sx_mag = sxp_r >> 18;
  assign sy_mag = ppp_pkg::SXP_W'(syp_r >> 14);
  assign d_full = w_m_r[MW-1:12];
  assign d_sat  = (d_full > (MW-12)'({ppp_pkg::DEPTH_W{1'b1}})) ?
                  {ppp_pkg::DEPTH_W{1'b1}} : d_full[ppp_pkg::DEPTH_W-1:0];

  logic                             vis_o_r;
  logic [ppp_pkg::SCR_W-1:0]        sx_o_r, sy_o_r;
  logic [ppp_pkg::DEPTH_W-1:0]      d_o_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vis_o_r <= vis_m_r;
      sx_o_r  <= vis_m_r ? sat32(sx_mag, negx_m_r) : '0;
      sy_o_r  <= vis_m_r ? sat32(sy_mag, !negy_m_r && (sy_mag != '0)) : '0;
      d_o_r   <= vis_m_r ? d_sat : '0;
    end
  end

  assign out_ch.valid    = v_r[NSTG-1];
  assign out_ch.visible  = vis_o_r;
  assign out_ch.screen_x = $signed(sx_o_r);
  assign out_ch.screen_y = $signed(sy_o_r);
  assign out_ch.depth    = d_o_r;

endmodule

/* hdl/ppp_checker.sv */
// Port-level checks of the projection block and their binding.
`timescale 1ns / 1ps

module ppp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             visible,
  input logic [ppp_pkg::SCR_W-1:0]        screen_x,
  input logic [ppp_pkg::SCR_W-1:0]        screen_y,
  input logic [ppp_pkg::DEPTH_W-1:0]      depth
);

  // a result held back keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(screen_x)
      && $stable(screen_y) && $stable(depth))
    else $error("stalled result changed");

  // hidden points carry zero fields
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !visible |-> screen_x == '0 && screen_y == '0 && depth == '0)
    else $error("hidden point with nonzero fields");

  // a visible point lies beyond the near limit, so depth is at least 6553 (0.1 in Q15.16, truncated)
  a_depth_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && visible |-> depth >= ppp_pkg::DEPTH_W'(6553))
    else $error("visible point too near");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind perspective_point_project ppp_checker u_ppp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .visible   (out_ch.visible),
  .screen_x  (out_ch.screen_x),
  .screen_y  (out_ch.screen_y),
  .depth     (out_ch.depth)
);

/* tb/tb.sv */
// Testbench for the perspective point projection block: directed and random points, exact projection check.
`timescale 1ns / 1ps

module tb;

  // One projected point as the block reports it
  typedef struct packed {
    logic        visible;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [30:0] depth;
  } proj_t;

  // Projection registers, kept in step with the block
  logic [47:0] row_x, row_y, row_w;
  logic [31:0] off_x, off_y, off_w;
  logic [15:0] half_w;

  // Clip row sum in Q.28
  function automatic logic signed [63:0] clip_sum(input logic [47:0] row,
      input logic [31:0] off, input logic signed [31:0] px, py, pz);
    logic signed [63:0] s;
    s = 64'(px) * 64'($signed(row[15:0])) + 64'(py) * 64'($signed(row[31:16]))
      + 64'(pz) * 64'($signed(row[47:32])) + 64'($signed(off)) * 64'sd4096;
    return s;
  endfunction

  // Long division |num|/den to Q2.30
  function automatic logic [63:0] ndc_quot(input logic [63:0] num, den);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] sat_signed(input logic [63:0] mag, input logic neg);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic proj_t project_point(input logic signed [31:0] px, py, pz);
    logic signed [63:0] cx, cy, cw;
    logic [63:0] ax, ay, w, nx, ny, sx, sy, d;
    proj_t p;
    p = '0;
    cx = clip_sum(row_x, off_x, px, py, pz);
    cy = clip_sum(row_y, off_y, px, py, pz);
    cw = clip_sum(row_w, off_w, px, py, pz);
    if (cw * 10 <= 64'sd268435456) return p;
    w = cw;
    ax = cx < 0 ? -cx : cx;
    ay = cy < 0 ? -cy : cy;
    if (ax * 5 > w * 11 || ay * 5 > w * 11) return p;
    nx = ndc_quot(ax, w);
    ny = ndc_quot(ay, w);
    sx = (nx * half_w) >> 18;
    sy = (ny * 360) >> 14;
    d = w >> 12;
    if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
    p.visible = 1'b1;
    p.screen_x = sat_signed(sx, cx < 0);
    p.screen_y = sat_signed(sy, !(cy < 0) && sy != 0);
    p.depth = d[30:0];
    return p;
  endfunction

  // Queue of expected projections, checked in order
  class proj_board;
    proj_t pending[$];
    int errors;
    function void note_point(proj_t p);
      pending.push_back(p);
    endfunction
    function void check_result(proj_t got);
      proj_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.visible !== e.visible)
        $display("%0t: visible exp %0b got %0b", $time, e.visible, got.visible);
      if (got.screen_x !== e.screen_x)
        $display("%0t: screen_x exp %h got %h", $time, e.screen_x, got.screen_x);
      if (got.screen_y !== e.screen_y)
        $display("%0t: screen_y exp %h got %h", $time, e.screen_y, got.screen_y);
      if (got.depth !== e.depth)
        $display("%0t: depth exp %h got %h", $time, e.depth, got.depth);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ppp_pkg::CFG_AW-1:0] paddr = '0;
  logic [ppp_pkg::CFG_DW-1:0] pwdata = '0;
  logic [ppp_pkg::CFG_DW-1:0] prdata;
  logic pready;
  int cycles = 0;
  int hold_off = 0;
  bit random_stall = 0;
  proj_board board;

  ppp_in_if in_ch();
  ppp_out_if out_ch();

  perspective_point_project dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(psel), .cfg_penable(penable), .cfg_pwrite(pwrite), .cfg_paddr(paddr),
    .cfg_pwdata(pwdata), .cfg_prdata(prdata), .cfg_pready(pready)
  );

  always #5 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.visible, out_ch.screen_x, out_ch.screen_y, out_ch.depth});
  end

  initial begin
    int gap;
    out_ch.ready <= 0;
    @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      gap = random_stall ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
    end
  end

  // Register write: setup, then access, then back to idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ppp_pkg::CFG_AW'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    case (idx)
      ppp_pkg::REG_ROW_X:  row_x = val[47:0];
      ppp_pkg::REG_ROW_Y:  row_y = val[47:0];
      ppp_pkg::REG_ROW_W:  row_w = val[47:0];
      ppp_pkg::REG_OFF_X:  off_x = val[31:0];
      ppp_pkg::REG_OFF_Y:  off_y = val[31:0];
      ppp_pkg::REG_OFF_W:  off_w = val[31:0];
      ppp_pkg::REG_HALF_W: half_w = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_point(input logic [31:0] px, py, pz);
    int gap;
    gap = random_stall ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_point(project_point(px, py, pz));
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'h1000;
      1: return 16'hF000;
      2: return 16'h0000;
      3: return 16'h7FFF;
      4: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Points within +-10 mostly, full range sometimes
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
  endfunction

  task automatic random_points(input int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    board = new();
    in_ch.valid <= 0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_z <= '0;
    row_x = '0; row_y = '0; row_w = '0;
    off_x = '0; off_y = '0; off_w = ppp_pkg::OFF_W_RST; half_w = ppp_pkg::HALF_W_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset settings: w is always 1, so every point maps to the center
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_point(0, 0, 0);
    drain();

    // Camera looking down z: x'=x, y'=y, w=z
    write_reg(ppp_pkg::REG_ROW_X, 48'h0000_0000_1000);
    write_reg(ppp_pkg::REG_ROW_Y, 48'h0000_1000_0000);
    write_reg(ppp_pkg::REG_ROW_W, 48'h1000_0000_0000);
    write_reg(ppp_pkg::REG_OFF_W, 0);
    write_reg(ppp_pkg::REG_HALF_W, 16'hFFFF);
    send_point(0, 0, 32'h0000_1999);           // w just at 0.1: hidden
    send_point(0, 0, 32'h0000_199A);           // just above 0.1
    send_point(32'h0002_3333, 0, 32'h0001_0000); // just under 2.2
    send_point(32'h0002_3333, 0, 32'h0001_0001);
    send_point(32'h0002_C000, 32'hFFFD_4000, 32'h0001_4000); // exactly on the bound
    send_point(32'hFFFD_4000, 32'h0002_C000, 32'h0001_4000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(0, 0, 32'h8000_0000);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000);
    send_point(1, 32'hFFFF_FFFF, 32'h0010_0000);
    drain();

    // Extreme coefficients and offsets, depth saturation
    write_reg(ppp_pkg::REG_ROW_W, 48'h7FFF_7FFF_7FFF);
    write_reg(ppp_pkg::REG_OFF_W, 32'h7FFF_FFFF);
    write_reg(ppp_pkg::REG_OFF_X, 32'h8000_0000);
    write_reg(ppp_pkg::REG_OFF_Y, 32'h7FFF_FFFF);
    write_reg(ppp_pkg::REG_HALF_W, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 0, 0);
    drain();

    // Long receiver hold-off so the pipeline fills and stalls the input
    hold_off = 300;
    random_stall = 1;
    random_points(60);
    drain();

    // Random phases with fresh settings
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(ppp_pkg::REG_ROW_X, {rand_coef(), rand_coef(), rand_coef()});
      write_reg(ppp_pkg::REG_ROW_Y, {rand_coef(), rand_coef(), rand_coef()});
      write_reg(ppp_pkg::REG_ROW_W, ph[0] ? {rand_coef(), rand_coef(), rand_coef()}
                                 : {16'h1000, 16'($urandom_range(0, 255)), 16'h0000});
      write_reg(ppp_pkg::REG_OFF_X, ph % 5 == 0 ? 32'h8000_0000
                : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
      write_reg(ppp_pkg::REG_OFF_Y, ph % 5 == 1 ? 32'h7FFF_FFFF
                : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
      write_reg(ppp_pkg::REG_OFF_W, ph % 5 == 2 ? $urandom : $urandom_range(0, 20 << 16));
      write_reg(ppp_pkg::REG_HALF_W,
                ph % 4 == 0 ? 16'hFFFF : (ph % 4 == 1 ? 16'h0 : 16'($urandom)));
      random_stall = (ph % 3 != 2);
      random_points(100);
      drain();
    end

    repeat (45) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
